### rtl/alm_pkg.sv
// Package for the audio level meter: payload types, register map, constants and FSM states.
package alm_pkg;

    localparam int MAX_FRAME_SAMPLES_DEF = 1024;
    localparam int DIVIDEND_W            = 42;
    localparam int DIVISOR_W             = 17;
    localparam int PROD_W                = 66;
    localparam int SQRT_STEPS            = 17;
    localparam int LOG_STEPS             = 16;
    localparam int ITER_W                = 5;
    localparam int ADDR_W                = 5;
    localparam logic [39:0] SQ_MAX       = 40'hFF_FFFF_FFFF;
    localparam logic [32:0] DB_PER_LOG2_Q16 = 33'd394566;

    localparam logic signed [15:0] SILENCE_DB_RST      = -16'sd25600;
    localparam logic signed [15:0] LEVEL_FLOOR_DB_RST  = -16'sd15360;
    localparam logic signed [15:0] SPEAKING_ON_DB_RST  = -16'sd10752;
    localparam logic signed [15:0] SPEAKING_OFF_DB_RST = -16'sd12288;
    localparam logic [15:0]        SMOOTHING_ALPHA_RST = 16'd22938;

    localparam logic [2:0] REG_SILENCE_DB      = 3'd0;
    localparam logic [2:0] REG_LEVEL_FLOOR_DB  = 3'd1;
    localparam logic [2:0] REG_SPEAKING_ON_DB  = 3'd2;
    localparam logic [2:0] REG_SPEAKING_OFF_DB = 3'd3;
    localparam logic [2:0] REG_SMOOTHING_ALPHA = 3'd4;

    typedef struct packed {
        logic signed [15:0] sample;
        logic               last_sample;
        logic               empty_frame;
    } in_t;

    typedef struct packed {
        logic               frame_valid;
        logic [16:0]        rms;
        logic [15:0]        peak;
        logic signed [15:0] level_db;
        logic signed [15:0] smooth_db;
        logic [16:0]        level;
        logic               speaking;
    } out_t;

    typedef struct packed {
        logic signed [15:0] silence_db;
        logic signed [15:0] level_floor_db;
        logic signed [15:0] speaking_on_db;
        logic signed [15:0] speaking_off_db;
        logic [15:0]        smoothing_alpha;
    } cfg_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_ACC,
        S_RMS_GO,
        S_RMS_WAIT,
        S_SQRT,
        S_NORM,
        S_LOG_MUL,
        S_LOG_SQ,
        S_DB_MUL,
        S_DB,
        S_SM_MUL,
        S_SM,
        S_LVL_CHK,
        S_LVL_GO,
        S_LVL_WAIT,
        S_FIN
    } state_t;

endpackage

### rtl/audio_level_meter_vad.sv
// Top level: frame RMS / peak / dB level meter with smoothed dB and speaking flag.
//
// Usage: PCM samples enter on the sample channel (valid/ready), the last one of a
// frame flagged by last_sample; a lone transaction with empty_frame set stands for
// a frame with no samples. One result transaction per frame leaves on the result
// channel. Configuration goes through the APB port while the block is idle; the
// user must keep to that, as the block itself does not enforce it. A sample is
// accepted, then squared through the shared multiplier and added, before the
// next one is taken. At frame end the sequencer runs a divide, a square root,
// up to 16 normalize steps, the log2 squaring and the smoothing, plus a divide
// for the level when it lies strictly between the bounds. An empty frame goes
// straight to the smoothing. sample_ready is low during this work.
// The result sits in an output register; a stalled receiver holds it there and
// the block keeps accepting samples, waiting only to deliver the next result.
// Reset clears the accumulators, the smoothing history and the speaking flag and
// loads the register defaults.
module audio_level_meter_vad #(
    parameter int MAX_FRAME_SAMPLES = alm_pkg::MAX_FRAME_SAMPLES_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        sample_valid,
    output logic                        sample_ready,
    input  alm_pkg::in_t                sample_data,
    output logic                        result_valid,
    input  logic                        result_ready,
    output alm_pkg::out_t               result_data,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [alm_pkg::ADDR_W-1:0]  paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready
);

    localparam int CNT_W = $clog2(MAX_FRAME_SAMPLES + 1);
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_FRAME_SAMPLES);

    alm_pkg::cfg_t   cfg;
    alm_pkg::state_t state_reg, state_next;

    logic [39:0]                  sum_reg;
    logic [CNT_W-1:0]             count_reg;
    logic [15:0]                  peak_reg;
    logic                         last_reg;
    logic                         prev_valid_reg;
    logic signed [15:0]           prev_s_reg;
    logic                         spk_reg;

    logic                         fvalid_reg;
    logic [16:0]                  rms_reg;
    logic [15:0]                  peak_out_reg;
    logic signed [15:0]           db_reg;
    logic signed [15:0]           s_reg;
    logic [16:0]                  level_reg;
    logic [33:0]                  sq_val_reg;
    logic [18:0]                  sq_rem_reg;
    logic [16:0]                  norm_reg;
    logic [4:0]                   shift_reg;
    logic [30:0]                  y_reg;
    logic [15:0]                  frac_reg;
    logic [alm_pkg::ITER_W-1:0]   iter_reg;
    logic signed [alm_pkg::PROD_W-1:0] prod_reg;

    logic                         result_valid_reg;
    alm_pkg::out_t                result_reg;

    logic signed [32:0]           mul_a, mul_b;
    logic                         div_start, div_busy;
    logic [alm_pkg::DIVIDEND_W-1:0] div_dividend, div_quotient;
    logic [alm_pkg::DIVISOR_W-1:0]  div_divisor;

    logic [16:0]                  mag;
    logic [40:0]                  sum_add;
    logic [20:0]                  sq_r2;
    logic [20:0]                  sq_trial;
    logic                         sq_ge;
    logic [31:0]                  yy;
    logic [20:0]                  neg;
    logic [39:0]                  db_rnd;
    logic signed [16:0]           diff_db;
    logic signed [alm_pkg::PROD_W-1:0] sm_t;
    logic signed [16:0]           num, span;
    logic                         spk_new;
    logic                         out_free;

    alm_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    alm_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .busy     (div_busy),
        .quotient (div_quotient)
    );

    assign mag      = sample_data.sample[15] ? 17'(-{sample_data.sample[15], sample_data.sample})
                                             : {1'b0, sample_data.sample};
    assign sum_add  = {1'b0, sum_reg} + {10'd0, prod_reg[30:0]};
    assign sq_r2    = {sq_rem_reg, sq_val_reg[33:32]};
    assign sq_trial = {2'b00, rms_reg, 2'b01};
    assign sq_ge    = sq_r2 >= sq_trial;
    assign yy       = prod_reg[61:30];
    assign neg      = {shift_reg, 16'd0} - {5'd0, frac_reg};
    assign db_rnd   = prod_reg[39:0] + 40'h80_0000;
    assign diff_db  = {db_reg[15], db_reg} - {prev_s_reg[15], prev_s_reg};
    assign sm_t     = prod_reg + alm_pkg::PROD_W'(32768);
    assign num      = {s_reg[15], s_reg} - {cfg.level_floor_db[15], cfg.level_floor_db};
    assign span     = -{cfg.level_floor_db[15], cfg.level_floor_db};
    assign spk_new  = spk_reg ? (s_reg >= cfg.speaking_off_db) : (s_reg >= cfg.speaking_on_db);
    assign out_free = !result_valid_reg || result_ready;

    assign result_valid = result_valid_reg;
    assign result_data  = result_reg;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            alm_pkg::S_IDLE:     if (sample_valid)
                                 begin
                                     state_next = sample_data.empty_frame ? alm_pkg::S_SM_MUL
                                                                          : alm_pkg::S_ACC;
                                 end
            alm_pkg::S_ACC:      state_next = last_reg ? alm_pkg::S_RMS_GO : alm_pkg::S_IDLE;
            alm_pkg::S_RMS_GO:   state_next = alm_pkg::S_RMS_WAIT;
            alm_pkg::S_RMS_WAIT: if (!div_busy) state_next = alm_pkg::S_SQRT;
            alm_pkg::S_SQRT:     if (iter_reg == alm_pkg::ITER_W'(alm_pkg::SQRT_STEPS - 1))
                                     state_next = alm_pkg::S_NORM;
            alm_pkg::S_NORM:     if (norm_reg == '0) state_next = alm_pkg::S_SM_MUL;
                                 else if (norm_reg[16]) state_next = alm_pkg::S_LOG_MUL;
            alm_pkg::S_LOG_MUL:  state_next = alm_pkg::S_LOG_SQ;
            alm_pkg::S_LOG_SQ:   state_next = (iter_reg == alm_pkg::ITER_W'(alm_pkg::LOG_STEPS - 1))
                                              ? alm_pkg::S_DB_MUL : alm_pkg::S_LOG_MUL;
            alm_pkg::S_DB_MUL:   state_next = alm_pkg::S_DB;
            alm_pkg::S_DB:       state_next = alm_pkg::S_SM_MUL;
            alm_pkg::S_SM_MUL:   state_next = alm_pkg::S_SM;
            alm_pkg::S_SM:       state_next = alm_pkg::S_LVL_CHK;
            alm_pkg::S_LVL_CHK:  state_next = (num <= 0 || num >= span) ? alm_pkg::S_FIN
                                                                        : alm_pkg::S_LVL_GO;
            alm_pkg::S_LVL_GO:   state_next = alm_pkg::S_LVL_WAIT;
            alm_pkg::S_LVL_WAIT: if (!div_busy) state_next = alm_pkg::S_FIN;
            alm_pkg::S_FIN:      if (out_free) state_next = alm_pkg::S_IDLE;
            default:             state_next = alm_pkg::S_IDLE;
        endcase
    end

    // outputs of the sequencer: handshake, divider launch, multiplier operands
    always_comb
    begin
        sample_ready = 1'b0;
        div_start    = 1'b0;
        div_dividend = {sum_reg, 2'b00};
        div_divisor  = alm_pkg::DIVISOR_W'(count_reg);
        mul_a        = {16'd0, mag};
        mul_b        = {16'd0, mag};
        unique case (state_reg)
            alm_pkg::S_IDLE:
            begin
                sample_ready = 1'b1;
            end
            alm_pkg::S_RMS_GO:
            begin
                div_start = 1'b1;
            end
            alm_pkg::S_LVL_GO:
            begin
                div_start    = 1'b1;
                div_dividend = {10'd0, num[15:0], 16'd0};
                div_divisor  = span;
            end
            alm_pkg::S_LOG_MUL:
            begin
                mul_a = {2'b00, y_reg};
                mul_b = {2'b00, y_reg};
            end
            alm_pkg::S_DB_MUL:
            begin
                mul_a = {12'd0, neg};
                mul_b = alm_pkg::DB_PER_LOG2_Q16;
            end
            alm_pkg::S_SM_MUL:
            begin
                mul_a = {17'd0, cfg.smoothing_alpha};
                mul_b = {{16{diff_db[16]}}, diff_db};
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= alm_pkg::S_IDLE;
            sum_reg          <= '0;
            count_reg        <= '0;
            peak_reg         <= '0;
            prev_valid_reg   <= 1'b0;
            prev_s_reg       <= '0;
            spk_reg          <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == alm_pkg::S_FIN && out_free)
            begin
                result_valid_reg <= 1'b1;
            end
            else if (result_valid_reg && result_ready)
            begin
                result_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                alm_pkg::S_IDLE:
                begin
                    if (sample_valid && !sample_data.empty_frame && mag[15:0] > peak_reg)
                    begin
                        peak_reg <= mag[15:0];
                    end
                end
                alm_pkg::S_ACC:
                begin
                    if (count_reg < CNT_MAX)
                    begin
                        sum_reg   <= sum_add[40] ? alm_pkg::SQ_MAX : sum_add[39:0];
                        count_reg <= count_reg + 1'b1;
                    end
                end
                alm_pkg::S_RMS_GO:
                begin
                    sum_reg   <= '0;
                    count_reg <= '0;
                    peak_reg  <= '0;
                end
                alm_pkg::S_FIN:
                begin
                    if (out_free)
                    begin
                        prev_valid_reg   <= fvalid_reg;
                        prev_s_reg       <= s_reg;
                        spk_reg          <= spk_new;
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= mul_a * mul_b;
        unique case (state_reg)
            alm_pkg::S_IDLE:
            begin
                last_reg <= sample_data.last_sample;
                if (sample_data.empty_frame)
                begin
                    fvalid_reg   <= 1'b0;
                    rms_reg      <= '0;
                    peak_out_reg <= '0;
                    db_reg       <= cfg.silence_db;
                end
            end
            alm_pkg::S_RMS_GO:
            begin
                fvalid_reg   <= 1'b1;
                peak_out_reg <= peak_reg;
            end
            alm_pkg::S_RMS_WAIT:
            begin
                sq_val_reg <= div_quotient[33:0];
                sq_rem_reg <= '0;
                rms_reg    <= '0;
                iter_reg   <= '0;
            end
            alm_pkg::S_SQRT:
            begin
                sq_val_reg <= {sq_val_reg[31:0], 2'b00};
                sq_rem_reg <= sq_ge ? 19'(sq_r2 - sq_trial) : sq_r2[18:0];
                rms_reg    <= {rms_reg[15:0], sq_ge};
                iter_reg   <= iter_reg + 1'b1;
                norm_reg   <= {rms_reg[15:0], sq_ge};
                shift_reg  <= '0;
            end
            alm_pkg::S_NORM:
            begin
                iter_reg <= '0;
                frac_reg <= '0;
                y_reg    <= {norm_reg, 14'd0};
                if (norm_reg == '0)
                begin
                    db_reg <= cfg.silence_db;
                end
                else if (!norm_reg[16])
                begin
                    norm_reg  <= {norm_reg[15:0], 1'b0};
                    shift_reg <= shift_reg + 1'b1;
                end
            end
            alm_pkg::S_LOG_SQ:
            begin
                iter_reg <= iter_reg + 1'b1;
                frac_reg <= {frac_reg[14:0], yy[31]};
                y_reg    <= yy[31] ? yy[31:1] : yy[30:0];
            end
            alm_pkg::S_DB:
            begin
                db_reg <= 16'(-db_rnd[39:24]);
            end
            alm_pkg::S_SM:
            begin
                s_reg <= prev_valid_reg ? 16'(prev_s_reg + 16'(sm_t >>> 16)) : db_reg;
            end
            alm_pkg::S_LVL_CHK:
            begin
                level_reg <= (num <= 0) ? 17'd0 : 17'd65536;
            end
            alm_pkg::S_LVL_WAIT:
            begin
                level_reg <= div_quotient[16:0];
            end
            alm_pkg::S_FIN:
            begin
                if (out_free)
                begin
                    result_reg.frame_valid <= fvalid_reg;
                    result_reg.rms         <= rms_reg;
                    result_reg.peak        <= peak_out_reg;
                    result_reg.level_db    <= db_reg;
                    result_reg.smooth_db   <= s_reg;
                    result_reg.level       <= level_reg;
                    result_reg.speaking    <= spk_new;
                end
            end
            default: ;
        endcase
    end

endmodule

### rtl/alm_regs.sv
// APB configuration register file for the level meter.
module alm_regs (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [alm_pkg::ADDR_W-1:0]  paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready,
    output alm_pkg::cfg_t               cfg
);

    alm_pkg::cfg_t cfg_reg;
    logic [2:0]    idx;
    logic          wr;

    assign idx    = paddr[4:2];
    assign wr     = psel && penable && pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.silence_db      <= alm_pkg::SILENCE_DB_RST;
            cfg_reg.level_floor_db  <= alm_pkg::LEVEL_FLOOR_DB_RST;
            cfg_reg.speaking_on_db  <= alm_pkg::SPEAKING_ON_DB_RST;
            cfg_reg.speaking_off_db <= alm_pkg::SPEAKING_OFF_DB_RST;
            cfg_reg.smoothing_alpha <= alm_pkg::SMOOTHING_ALPHA_RST;
        end
        else if (wr)
        begin
            unique case (idx)
                alm_pkg::REG_SILENCE_DB:      cfg_reg.silence_db      <= pwdata[15:0];
                alm_pkg::REG_LEVEL_FLOOR_DB:  cfg_reg.level_floor_db  <= pwdata[15:0];
                alm_pkg::REG_SPEAKING_ON_DB:  cfg_reg.speaking_on_db  <= pwdata[15:0];
                alm_pkg::REG_SPEAKING_OFF_DB: cfg_reg.speaking_off_db <= pwdata[15:0];
                alm_pkg::REG_SMOOTHING_ALPHA: cfg_reg.smoothing_alpha <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (idx)
            alm_pkg::REG_SILENCE_DB:      prdata = {{16{cfg_reg.silence_db[15]}},
                                                    cfg_reg.silence_db};
            alm_pkg::REG_LEVEL_FLOOR_DB:  prdata = {{16{cfg_reg.level_floor_db[15]}},
                                                    cfg_reg.level_floor_db};
            alm_pkg::REG_SPEAKING_ON_DB:  prdata = {{16{cfg_reg.speaking_on_db[15]}},
                                                    cfg_reg.speaking_on_db};
            alm_pkg::REG_SPEAKING_OFF_DB: prdata = {{16{cfg_reg.speaking_off_db[15]}},
                                                    cfg_reg.speaking_off_db};
            alm_pkg::REG_SMOOTHING_ALPHA: prdata = {16'd0, cfg_reg.smoothing_alpha};
            default:                      prdata = 32'd0;
        endcase
    end

endmodule

### rtl/alm_div.sv
// Iterative restoring divider, one quotient bit per cycle.
module alm_div (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    input  logic [alm_pkg::DIVIDEND_W-1:0]     dividend,
    input  logic [alm_pkg::DIVISOR_W-1:0]      divisor,
    output logic                               busy,
    output logic [alm_pkg::DIVIDEND_W-1:0]     quotient
);

    localparam int CNT_W = $clog2(alm_pkg::DIVIDEND_W);
    localparam logic [CNT_W-1:0] LAST = CNT_W'(alm_pkg::DIVIDEND_W - 1);

    logic                             busy_reg;
    logic [CNT_W-1:0]                 cnt_reg;
    logic [alm_pkg::DIVIDEND_W-1:0]   quo_reg;
    logic [alm_pkg::DIVISOR_W-1:0]    rem_reg;
    logic [alm_pkg::DIVISOR_W-1:0]    div_reg;
    logic [alm_pkg::DIVISOR_W:0]      shifted;
    logic [alm_pkg::DIVISOR_W:0]      diff;
    logic                             ge;

    assign shifted  = {rem_reg, quo_reg[alm_pkg::DIVIDEND_W-1]};
    assign diff     = shifted - {1'b0, div_reg};
    assign ge       = shifted >= {1'b0, div_reg};
    assign busy     = busy_reg;
    assign quotient = quo_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= '0;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg + 1'b1;
            if (cnt_reg == LAST)
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            div_reg <= divisor;
        end
        else if (busy_reg)
        begin
            quo_reg <= {quo_reg[alm_pkg::DIVIDEND_W-2:0], ge};
            rem_reg <= ge ? diff[alm_pkg::DIVISOR_W-1:0] : shifted[alm_pkg::DIVISOR_W-1:0];
        end
    end

endmodule

### rtl/alm_checker.sv
// Port-level assertions for the level meter, bound to the top level.
module alm_checker (
    input logic          clk,
    input logic          rst_n,
    input logic          sample_valid,
    input logic          sample_ready,
    input alm_pkg::in_t  sample_data,
    input logic          result_valid,
    input logic          result_ready,
    input alm_pkg::out_t result_data
);

    // a stalled result stays put
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid && $stable(result_data))
        else $error("result dropped or changed while stalled");

    // every accepted sample occupies the sequencer, so samples are never taken back to back
    assert property (@(posedge clk) disable iff (!rst_n)
        sample_valid && sample_ready |=> !sample_ready)
        else $error("sample taken back to back");

    // empty frames report no signal
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_data.frame_valid |->
            result_data.rms == 17'd0 && result_data.peak == 16'd0)
        else $error("empty frame with nonzero rms or peak");

    // rms and level never exceed full scale
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> result_data.rms <= 17'd65536 && result_data.level <= 17'd65536)
        else $error("rms or level out of range");

endmodule

bind audio_level_meter_vad alm_checker u_alm_checker (.*);
